// ===== design/twgd_pkg.sv =====
package twgd_pkg;

    // Binary-angle resolution and CORDIC depth.
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int CNT_W        = $clog2(CORDIC_N);
    localparam int ANGLE_SHIFT  = 32 - ANGLE_BITS;

    // CORDIC vector word: 9-bit pixel offset with 16 fraction bits plus gain headroom.
    localparam int CORDIC_FRAC  = 16;
    localparam int CW           = 28;

    localparam longint unsigned TURN = longint'(1) << ANGLE_BITS;
    localparam logic [ANGLE_BITS-1:0] ANG_HALF = ANGLE_BITS'(TURN / 2);
    localparam logic [ANGLE_BITS-1:0] ANG_20   = ANGLE_BITS'(TURN / 18);
    localparam logic [ANGLE_BITS-1:0] ANG_200  = ANGLE_BITS'(TURN * 5 / 9);
    localparam logic [ANGLE_BITS-1:0] ANG_340  = ANGLE_BITS'(TURN - TURN / 18);

    localparam logic [4:0] CENTER_LIMIT = 5'd30;
    localparam logic [4:0] BUTTON_LIMIT = 5'd20;

    // Event bit positions in the sticky flag word.
    localparam int EV_STEP_RIGHT  = 0;
    localparam int EV_STEP_LEFT   = 1;
    localparam int EV_TAP_CENTER  = 2;
    localparam int EV_TAP_MENU    = 3;
    localparam int EV_TAP_FORWARD = 4;
    localparam int EV_TAP_REWIND  = 5;
    localparam int EV_TAP_PLAY    = 6;
    localparam int EV_W           = 7;

    // Configuration register indexes.
    localparam logic [3:0] CFG_CENTER_X     = 4'd0;
    localparam logic [3:0] CFG_CENTER_Y     = 4'd1;
    localparam logic [3:0] CFG_OUTER_RADIUS = 4'd2;
    localparam logic [3:0] CFG_INNER_RADIUS = 4'd3;
    localparam logic [3:0] CFG_MENU_POS     = 4'd4;
    localparam logic [3:0] CFG_FORWARD_POS  = 4'd5;
    localparam logic [3:0] CFG_REWIND_POS   = 4'd6;
    localparam logic [3:0] CFG_PLAY_POS     = 4'd7;

    localparam logic [7:0]  RST_CENTER_X     = 8'd128;
    localparam logic [7:0]  RST_CENTER_Y     = 8'd96;
    localparam logic [7:0]  RST_OUTER_RADIUS = 8'd80;
    localparam logic [7:0]  RST_INNER_RADIUS = 8'd30;
    localparam logic [15:0] RST_MENU_POS     = 16'd51456;
    localparam logic [15:0] RST_FORWARD_POS  = 16'd55;
    localparam logic [15:0] RST_REWIND_POS   = 16'd201;
    localparam logic [15:0] RST_PLAY_POS     = 16'd14080;

    // atan(2^-i) in 2^32 units per turn.
    localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // Round the table entry to the angle resolution.
    function automatic logic [ANGLE_BITS-1:0] atan_step(input logic [CNT_W-1:0] idx);
        logic [32:0] sum;
        sum = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (ANGLE_SHIFT - 1));
        return sum[ANGLE_SHIFT +: ANGLE_BITS];
    endfunction

    typedef struct packed {
        logic load;     // capture the accepted sample
        logic prep;     // press start, squares
        logic resolve;  // ring test, ring entry, tap test, load CORDIC lanes
        logic iterate;  // one CORDIC micro-rotation
        logic turn;     // step decision
        logic emit;     // write the result beat, update previous point
    } cmd_t;

    typedef struct packed {
        logic need_turn;
        logic cordic_last;
        logic out_free;
    } status_t;

endpackage

// ===== design/twgd_cordic_lane.sv =====
module twgd_cordic_lane (
    input  logic                                aclk,
    input  logic                                load,
    input  logic                                advance,
    input  logic [twgd_pkg::CNT_W-1:0]          step,
    input  logic signed [8:0]                   vec_x,
    input  logic signed [8:0]                   vec_y,
    output logic [twgd_pkg::ANGLE_BITS-1:0]     angle
);

    logic signed [twgd_pkg::CW-1:0]    x_reg, y_reg, x_next, y_next;
    logic [twgd_pkg::ANGLE_BITS-1:0]   z_reg, z_next;

    always_comb begin
        logic signed [twgd_pkg::CW-1:0]  x_load, y_load, x_sh, y_sh;
        logic [twgd_pkg::ANGLE_BITS-1:0] t;
        x_load = {{(twgd_pkg::CW - 9 - twgd_pkg::CORDIC_FRAC){vec_x[8]}}, vec_x,
                  {twgd_pkg::CORDIC_FRAC{1'b0}}};
        y_load = {{(twgd_pkg::CW - 9 - twgd_pkg::CORDIC_FRAC){vec_y[8]}}, vec_y,
                  {twgd_pkg::CORDIC_FRAC{1'b0}}};
        x_sh   = x_reg >>> step;
        y_sh   = y_reg >>> step;
        t      = twgd_pkg::atan_step(step);
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (load) begin
            // Fold the left half plane over by half a turn.
            if (vec_x[8]) begin
                x_next = -x_load;
                y_next = -y_load;
                z_next = twgd_pkg::ANG_HALF;
            end else begin
                x_next = x_load;
                y_next = y_load;
                z_next = '0;
            end
        end else if (advance) begin
            if (!y_reg[twgd_pkg::CW-1]) begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + t;
            end else begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - t;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign angle = z_reg;

endmodule

// ===== design/twgd_datapath.sv =====
module twgd_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  twgd_pkg::cmd_t                cmd,
    output twgd_pkg::status_t             sts,
    input  logic                          in_touching,
    input  logic [7:0]                    in_touch_x,
    input  logic [7:0]                    in_touch_y,
    input  logic                          in_take_status,
    input  logic                          cfg_write,
    input  logic [3:0]                    cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [twgd_pkg::EV_W-1:0]     out_events
);

    // Configuration registers.
    logic [7:0]  center_x_reg, center_y_reg, outer_radius_reg, inner_radius_reg;
    logic [15:0] menu_pos_reg, forward_pos_reg, rewind_pos_reg, play_pos_reg;

    // Captured sample and ring-test terms.
    logic               pen_reg, take_reg;
    logic signed [8:0]  px_reg, py_reg;
    logic [15:0]        sq_x_reg, sq_y_reg, outer_sq_reg, inner_sq_reg;

    // Gesture state.
    logic signed [8:0]  anchor_x_reg, anchor_y_reg, previous_x_reg, previous_y_reg;
    logic               in_ring_reg, has_moved_reg, pen_was_down_reg;
    logic [twgd_pkg::EV_W-1:0] pending_reg;

    logic                          out_valid_reg;
    logic [twgd_pkg::EV_W-1:0]     out_events_reg;
    logic [twgd_pkg::CNT_W-1:0]    step_reg;

    logic [twgd_pkg::ANGLE_BITS-1:0] angle_cur, angle_anc, turn_delta;
    logic [16:0]       rad_sq;
    logic              in_window;
    logic signed [8:0] neg_px, neg_py;
    logic [7:0]        abs_px, abs_py;
    logic [twgd_pkg::EV_W-1:0] tap_events;

    function automatic logic near_point(
        input logic signed [8:0] ax,
        input logic signed [8:0] ay,
        input logic signed [8:0] qx,
        input logic signed [8:0] qy,
        input logic [15:0]       pos,
        input logic [4:0]        lim
    );
        logic signed [9:0] bx, by, l, dax, day, dqx, dqy;
        bx  = {{2{pos[7]}}, pos[7:0]};
        by  = {{2{pos[15]}}, pos[15:8]};
        l   = $signed({5'b0, lim});
        dax = {ax[8], ax} - bx;
        day = {ay[8], ay} - by;
        dqx = {qx[8], qx} - bx;
        dqy = {qy[8], qy} - by;
        return (dax < l) && (dax > -l) && (day < l) && (day > -l) &&
               (dqx < l) && (dqx > -l) && (dqy < l) && (dqy > -l);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg     <= twgd_pkg::RST_CENTER_X;
            center_y_reg     <= twgd_pkg::RST_CENTER_Y;
            outer_radius_reg <= twgd_pkg::RST_OUTER_RADIUS;
            inner_radius_reg <= twgd_pkg::RST_INNER_RADIUS;
            menu_pos_reg     <= twgd_pkg::RST_MENU_POS;
            forward_pos_reg  <= twgd_pkg::RST_FORWARD_POS;
            rewind_pos_reg   <= twgd_pkg::RST_REWIND_POS;
            play_pos_reg     <= twgd_pkg::RST_PLAY_POS;
        end else if (cfg_write) begin
            unique case (cfg_index)
                twgd_pkg::CFG_CENTER_X:     center_x_reg     <= cfg_data[7:0];
                twgd_pkg::CFG_CENTER_Y:     center_y_reg     <= cfg_data[7:0];
                twgd_pkg::CFG_OUTER_RADIUS: outer_radius_reg <= cfg_data[7:0];
                twgd_pkg::CFG_INNER_RADIUS: inner_radius_reg <= cfg_data[7:0];
                twgd_pkg::CFG_MENU_POS:     menu_pos_reg     <= cfg_data;
                twgd_pkg::CFG_FORWARD_POS:  forward_pos_reg  <= cfg_data;
                twgd_pkg::CFG_REWIND_POS:   rewind_pos_reg   <= cfg_data;
                twgd_pkg::CFG_PLAY_POS:     play_pos_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sample capture and squares (payload, no reset).
    assign neg_px = -px_reg;
    assign neg_py = -py_reg;
    assign abs_px = px_reg[8] ? neg_px[7:0] : px_reg[7:0];
    assign abs_py = py_reg[8] ? neg_py[7:0] : py_reg[7:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pen_reg  <= in_touching;
            take_reg <= in_take_status;
            px_reg   <= $signed({1'b0, in_touch_x}) - $signed({1'b0, center_x_reg});
            py_reg   <= $signed({1'b0, in_touch_y}) - $signed({1'b0, center_y_reg});
        end
        if (cmd.prep) begin
            sq_x_reg     <= {8'b0, abs_px} * {8'b0, abs_px};
            sq_y_reg     <= {8'b0, abs_py} * {8'b0, abs_py};
            outer_sq_reg <= {8'b0, outer_radius_reg} * {8'b0, outer_radius_reg};
            inner_sq_reg <= {8'b0, inner_radius_reg} * {8'b0, inner_radius_reg};
        end
    end

    assign rad_sq    = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign in_window = (rad_sq <= {1'b0, outer_sq_reg}) && (rad_sq >= {1'b0, inner_sq_reg});

    // Tap classification, first match wins.
    always_comb begin
        tap_events = '0;
        if (near_point(anchor_x_reg, anchor_y_reg, previous_x_reg, previous_y_reg,
                       16'h0000, twgd_pkg::CENTER_LIMIT))
            tap_events[twgd_pkg::EV_TAP_CENTER] = 1'b1;
        else if (near_point(anchor_x_reg, anchor_y_reg, previous_x_reg, previous_y_reg,
                            menu_pos_reg, twgd_pkg::BUTTON_LIMIT))
            tap_events[twgd_pkg::EV_TAP_MENU] = 1'b1;
        else if (near_point(anchor_x_reg, anchor_y_reg, previous_x_reg, previous_y_reg,
                            forward_pos_reg, twgd_pkg::BUTTON_LIMIT))
            tap_events[twgd_pkg::EV_TAP_FORWARD] = 1'b1;
        else if (near_point(anchor_x_reg, anchor_y_reg, previous_x_reg, previous_y_reg,
                            rewind_pos_reg, twgd_pkg::BUTTON_LIMIT))
            tap_events[twgd_pkg::EV_TAP_REWIND] = 1'b1;
        else if (near_point(anchor_x_reg, anchor_y_reg, previous_x_reg, previous_y_reg,
                            play_pos_reg, twgd_pkg::BUTTON_LIMIT))
            tap_events[twgd_pkg::EV_TAP_PLAY] = 1'b1;
    end

    // Two CORDIC lanes share one step counter: current point and anchor.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (cmd.resolve) begin
            step_reg <= '0;
        end else if (cmd.iterate) begin
            step_reg <= step_reg + twgd_pkg::CNT_W'(1);
        end
    end

    twgd_cordic_lane u_lane_cur (
        .aclk    (aclk),
        .load    (cmd.resolve),
        .advance (cmd.iterate),
        .step    (step_reg),
        .vec_x   (px_reg),
        .vec_y   (py_reg),
        .angle   (angle_cur)
    );

    twgd_cordic_lane u_lane_anc (
        .aclk    (aclk),
        .load    (cmd.resolve),
        .advance (cmd.iterate),
        .step    (step_reg),
        .vec_x   (anchor_x_reg),
        .vec_y   (anchor_y_reg),
        .angle   (angle_anc)
    );

    assign turn_delta = angle_cur - angle_anc;

    // Gesture state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anchor_x_reg     <= '0;
            anchor_y_reg     <= '0;
            previous_x_reg   <= '0;
            previous_y_reg   <= '0;
            in_ring_reg      <= 1'b0;
            has_moved_reg    <= 1'b0;
            pen_was_down_reg <= 1'b0;
            pending_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cmd.prep && pen_reg && !pen_was_down_reg) begin
                anchor_x_reg     <= px_reg;
                anchor_y_reg     <= py_reg;
                previous_x_reg   <= px_reg;
                previous_y_reg   <= py_reg;
                pen_was_down_reg <= 1'b1;
                has_moved_reg    <= 1'b0;
            end
            if (cmd.resolve) begin
                if (pen_reg) begin
                    if (!in_window) begin
                        in_ring_reg <= 1'b0;
                    end else if (!in_ring_reg) begin
                        in_ring_reg  <= 1'b1;
                        anchor_x_reg <= px_reg;
                        anchor_y_reg <= py_reg;
                    end
                end else begin
                    if (!has_moved_reg && pen_was_down_reg)
                        pending_reg <= pending_reg | tap_events;
                    in_ring_reg      <= 1'b0;
                    pen_was_down_reg <= 1'b0;
                end
            end
            if (cmd.turn) begin
                if (turn_delta > twgd_pkg::ANG_20 && turn_delta < twgd_pkg::ANG_200) begin
                    anchor_x_reg  <= px_reg;
                    anchor_y_reg  <= py_reg;
                    has_moved_reg <= 1'b1;
                    pending_reg[twgd_pkg::EV_STEP_RIGHT] <= 1'b1;
                end else if (turn_delta >= twgd_pkg::ANG_200 &&
                             turn_delta < twgd_pkg::ANG_340) begin
                    anchor_x_reg  <= px_reg;
                    anchor_y_reg  <= py_reg;
                    has_moved_reg <= 1'b1;
                    pending_reg[twgd_pkg::EV_STEP_LEFT] <= 1'b1;
                end
            end
            if (cmd.emit) begin
                previous_x_reg <= px_reg;
                previous_y_reg <= py_reg;
                out_valid_reg  <= 1'b1;
                if (take_reg)
                    pending_reg <= '0;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit)
            out_events_reg <= take_reg ? pending_reg : '0;
    end

    assign sts.need_turn   = pen_reg && in_window && in_ring_reg;
    assign sts.cordic_last = (step_reg == twgd_pkg::CNT_W'(twgd_pkg::CORDIC_N - 1));
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_events = out_events_reg;

endmodule

// ===== design/twgd_ctrl.sv =====
module twgd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  twgd_pkg::status_t  sts,
    output twgd_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RING,
        ST_CORDIC,
        ST_TURN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = in_valid;
                if (in_valid)
                    state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_RING;
            end
            ST_RING: begin
                cmd.resolve = 1'b1;
                state_next  = sts.need_turn ? ST_CORDIC : ST_FINISH;
            end
            ST_CORDIC: begin
                cmd.iterate = 1'b1;
                if (sts.cordic_last)
                    state_next = ST_TURN;
            end
            ST_TURN: begin
                cmd.turn   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.emit = sts.out_free;
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// ===== design/touch_wheel_gesture_decoder_unit.sv =====
// Touch click-wheel gesture decoder.
// Input stream (s_*): one touch sample per beat. The block tracks the press, measures
// the turn around the wheel ring with two CORDIC lanes and classifies taps on release.
// Output stream (m_*): exactly one beat per sample, carrying the sticky event flags
// when take_status was set on that sample (the flags then clear), all zeros otherwise.
// Configuration channel (cfg_*): register index and data; always ready, write only
// while no sample is in flight.
// Processing: a sample that needs a turn measurement passes the prep, ring, CORDIC,
// turn and finish steps, the CORDIC step running the iterative loop one micro-rotation
// per cycle; any other sample goes from the ring step straight to the finish step.
// Throughput: one sample at a time; s_tready rises again as the result is written
// to the output register, so a new sample can be taken while that beat waits.
// The input stays busy from acceptance until the finish step writes the result.
// Stall: if m_tready is low when a result is ready, hold the sample in the finish
// step until the output register frees; nothing is dropped.
// Reset: aresetn low clears the gesture state, the sticky flags and the output
// register and loads the default wheel geometry.
module touch_wheel_gesture_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [0] touching, [8:1] touch_x, [16:9] touch_y,
                                   // [17] take_status, [23:18] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] step_right, [1] step_left, [2] tap_center,
                                   // [3] tap_menu, [4] tap_forward, [5] tap_rewind,
                                   // [6] tap_play, [7] zero

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    twgd_pkg::cmd_t    cmd;
    twgd_pkg::status_t sts;
    logic [twgd_pkg::EV_W-1:0] events;

    // Registers are plain flops; accept a write every cycle.
    assign cfg_ready = 1'b1;

    twgd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    twgd_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_touching    (s_tdata[0]),
        .in_touch_x     (s_tdata[8:1]),
        .in_touch_y     (s_tdata[16:9]),
        .in_take_status (s_tdata[17]),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_events     (events)
    );

    assign m_tdata = {1'b0, events};

    // A sample in flight blocks the next one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a sample was in flight");

    // A new result beat only appears at the end of a sample's processing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result beat without an accepted sample");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

// ===== dv/testbench.sv =====
module testbench;

    // Quiet cycles allowed before the run is declared hung; a long output hold-off
    // plus a full CORDIC pass fits many times over.
    localparam int QUIET_LIMIT  = 3000;
    // Cycles to let pass once the expected-flags store is empty.
    localparam int DRAIN_CYCLES = twgd_pkg::CORDIC_N + 8;
    // Length of the deliberate output hold-off.
    localparam int HOLD_CYCLES  = 300;
    localparam real DEG         = 3.14159265358979 / 180.0;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [0] touching, [8:1] touch_x, [16:9] touch_y,
                            // [17] take_status, [23:18] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [0] step_right, [1] step_left, [2] tap_center,
                            // [3] tap_menu, [4] tap_forward, [5] tap_rewind,
                            // [6] tap_play, [7] zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [15:0] cfg_data;

    touch_wheel_gesture_decoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the wheel geometry, updated on each accepted register write.
    logic [7:0]  ctr_x, ctr_y, r_out, r_in;
    logic [15:0] btn_pos [4];   // menu, forward, rewind, play

    // Shadow of the gesture state.
    logic signed [8:0] anc_x, anc_y, last_x, last_y;
    logic              ringed, stepped, pressed;
    logic [twgd_pkg::EV_W-1:0] sticky;

    // Flags expected on the output, oldest first.
    logic [twgd_pkg::EV_W-1:0] expected_flags [$];

    int errors     = 0;
    int quiet      = 0;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int hold_armed = 0;
    int hold_taken = 0;
    int hold_left  = 0;

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Gesture predictor
    // ------------------------------------------------------------------

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Binary angle of a pixel offset: vectoring CORDIC on 16-bit-fraction values,
    // floor shifts, left half-plane folded over by half a turn first.
    function automatic logic [twgd_pkg::ANGLE_BITS-1:0] bin_angle(input int x, input int y);
        longint vx, vy, nx, ny, t;
        logic [twgd_pkg::ANGLE_BITS-1:0] z;
        int i;
        vx = longint'(x) * 65536;
        vy = longint'(y) * 65536;
        z  = '0;
        if (vx < 0) begin
            vx = -vx;
            vy = -vy;
            z  = twgd_pkg::ANG_HALF;
        end
        for (i = 0; i < twgd_pkg::CORDIC_N; i++) begin
            // Round the per-turn table entry to the angle width.
            t = (longint'(twgd_pkg::ATAN_TURN32[i]) +
                 (longint'(1) << (twgd_pkg::ANGLE_SHIFT - 1))) >>> twgd_pkg::ANGLE_SHIFT;
            if (vy >= 0) begin
                nx = vx + (vy >>> i);
                ny = vy - (vx >>> i);
                z  = z + t[twgd_pkg::ANGLE_BITS-1:0];
            end else begin
                nx = vx - (vy >>> i);
                ny = vy + (vx >>> i);
                z  = z - t[twgd_pkg::ANGLE_BITS-1:0];
            end
            vx = nx;
            vy = ny;
        end
        return z;
    endfunction

    // Both the anchor and the previous point lie inside the box around (bx, by).
    function automatic logic within_box(input int bx, input int by, input int lim);
        return mag(anc_x - bx) < lim && mag(anc_y - by) < lim &&
               mag(last_x - bx) < lim && mag(last_y - by) < lim;
    endfunction

    // Advance the gesture state by one sample and return the flags it reports.
    function automatic logic [twgd_pkg::EV_W-1:0] decode_sample(input logic [23:0] beat);
        logic pen, take, hit;
        int px, py, rad_sq, k;
        logic signed [8:0] sx, sy;
        logic [twgd_pkg::ANGLE_BITS-1:0] dz;
        logic [twgd_pkg::EV_W-1:0] flags;
        pen  = beat[0];
        take = beat[17];
        px   = int'(beat[8:1]) - int'(ctr_x);
        py   = int'(beat[16:9]) - int'(ctr_y);
        sx   = 9'(px);
        sy   = 9'(py);
        hit  = 1'b0;

        // Press start: seed anchor and previous point.
        if (!pressed && pen) begin
            anc_x   = sx;
            anc_y   = sy;
            last_x  = sx;
            last_y  = sy;
            pressed = 1'b1;
            stepped = 1'b0;
        end

        if (pen) begin
            rad_sq = px * px + py * py;
            if (rad_sq > int'(r_out) * int'(r_out) || rad_sq < int'(r_in) * int'(r_in)) begin
                ringed = 1'b0;
            end else if (!ringed) begin
                // Entering the ring: re-anchor, no turn measured.
                ringed = 1'b1;
                anc_x  = sx;
                anc_y  = sy;
            end else begin
                dz = bin_angle(px, py) - bin_angle(anc_x, anc_y);
                // Turns of 180 to 200 degrees still count as right.
                if (dz > twgd_pkg::ANG_20 && dz < twgd_pkg::ANG_200) begin
                    anc_x   = sx;
                    anc_y   = sy;
                    stepped = 1'b1;
                    sticky[twgd_pkg::EV_STEP_RIGHT] = 1'b1;
                end else if (dz >= twgd_pkg::ANG_200 && dz < twgd_pkg::ANG_340) begin
                    anc_x   = sx;
                    anc_y   = sy;
                    stepped = 1'b1;
                    sticky[twgd_pkg::EV_STEP_LEFT] = 1'b1;
                end
            end
        end else begin
            // Release after a press without a step: classify the tap, first match wins.
            if (!stepped && pressed) begin
                if (within_box(0, 0, twgd_pkg::CENTER_LIMIT)) begin
                    sticky[twgd_pkg::EV_TAP_CENTER] = 1'b1;
                end else begin
                    for (k = 0; k < 4; k++) begin
                        if (!hit && within_box($signed(btn_pos[k][7:0]),
                                               $signed(btn_pos[k][15:8]),
                                               twgd_pkg::BUTTON_LIMIT)) begin
                            sticky[twgd_pkg::EV_TAP_MENU + k] = 1'b1;
                            hit = 1'b1;
                        end
                    end
                end
            end
            ringed  = 1'b0;
            pressed = 1'b0;
        end

        // The previous point follows every sample, the release one included.
        last_x = sx;
        last_y = sy;
        flags  = take ? sticky : '0;
        if (take) sticky = '0;
        return flags;
    endfunction

    // ------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------

    // Check result beats first, then predict the input beat taken at the same edge.
    always @(posedge aclk) begin
        logic [7:0] want;
        int f;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_flags.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected: actual %b", $time, m_tdata);
            end else begin
                want = {1'b0, expected_flags.pop_front()};
                for (f = 0; f < 8; f++) begin
                    if (m_tdata[f] !== want[f]) begin
                        errors++;
                        $display("%0t: flag bit %0d mismatch: expected %b actual %b (beat %b vs %b)",
                                 $time, f, want[f], m_tdata[f], want, m_tdata);
                    end
                end
            end
        end
        if (aresetn && s_tvalid && s_tready)
            expected_flags.push_back(decode_sample(s_tdata));
    end

    // Hang detection: count edges at which no beat moves on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: stall at random, or hold off for a long stretch when armed.
    always @(negedge aclk) begin
        if (hold_armed != hold_taken) begin
            hold_taken = hold_armed;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one sample; return at the falling edge after it is taken.
    task automatic send_sample(input logic pen, input logic [7:0] x, input logic [7:0] y,
                               input logic take);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'b0, take, y, x, pen};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop the input and wait until every expected beat has arrived.
    task automatic wait_drain();
        s_tvalid = 1'b0;
        while (expected_flags.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            twgd_pkg::CFG_CENTER_X:     ctr_x      = val[7:0];
            twgd_pkg::CFG_CENTER_Y:     ctr_y      = val[7:0];
            twgd_pkg::CFG_OUTER_RADIUS: r_out      = val[7:0];
            twgd_pkg::CFG_INNER_RADIUS: r_in       = val[7:0];
            twgd_pkg::CFG_MENU_POS:     btn_pos[0] = val;
            twgd_pkg::CFG_FORWARD_POS:  btn_pos[1] = val;
            twgd_pkg::CFG_REWIND_POS:   btn_pos[2] = val;
            twgd_pkg::CFG_PLAY_POS:     btn_pos[3] = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Reprogram the whole geometry once idle; junk goes into the unused upper
    // byte of the 8-bit registers and into one unmapped index.
    task automatic program_geometry(input logic [7:0] cx, input logic [7:0] cy,
                                    input logic [7:0] ro, input logic [7:0] ri,
                                    input logic [15:0] pm, input logic [15:0] pf,
                                    input logic [15:0] pr, input logic [15:0] pp);
        wait_drain();
        write_reg(twgd_pkg::CFG_CENTER_X,     {8'($urandom_range(255)), cx});
        write_reg(twgd_pkg::CFG_CENTER_Y,     {8'($urandom_range(255)), cy});
        write_reg(twgd_pkg::CFG_OUTER_RADIUS, {8'($urandom_range(255)), ro});
        write_reg(twgd_pkg::CFG_INNER_RADIUS, {8'($urandom_range(255)), ri});
        write_reg(twgd_pkg::CFG_MENU_POS,     pm);
        write_reg(twgd_pkg::CFG_FORWARD_POS,  pf);
        write_reg(twgd_pkg::CFG_REWIND_POS,   pr);
        write_reg(twgd_pkg::CFG_PLAY_POS,     pp);
        write_reg(4'($urandom_range(15, twgd_pkg::CFG_PLAY_POS + 1)), 16'($urandom));
        cfg_valid = 1'b0;
    endtask

    // Clamp a center-relative position onto the panel.
    function automatic logic [7:0] screen_coord(input int base, input real off, input int top);
        int v;
        v = base + $rtoi(off);
        if (v < 0) v = 0;
        if (v > top) v = top;
        return v[7:0];
    endfunction

    // Signed pixel offset in -70..70 as a register byte.
    function automatic logic [7:0] rand_offset();
        int v;
        v = $urandom_range(140);
        v -= 70;
        return v[7:0];
    endfunction

    // Random traffic: mostly ring strokes and taps with random content, some noise.
    task automatic run_gestures(input int n_items);
        int done, kind, count, k, r, bx, by, sgn, jx, jy;
        real ang, turn_deg;
        done = 0;
        while (done < n_items) begin
            kind = $urandom_range(9);
            if (kind < 5) begin
                // Stroke around the ring, sometimes off it, with the odd half-turn jump.
                if (r_in <= r_out && $urandom_range(9) != 0)
                    r = $urandom_range(r_out, r_in);
                else
                    r = $urandom_range(160);
                ang   = $urandom_range(359) * DEG;
                sgn   = $urandom_range(1) ? 1 : -1;
                count = $urandom_range(10, 2);
                for (k = 0; k < count; k++) begin
                    send_sample(1'b1, screen_coord(ctr_x, r * $cos(ang), 255),
                                screen_coord(ctr_y, r * $sin(ang), 191),
                                $urandom_range(3) == 0);
                    if ($urandom_range(7) == 0) sgn = -sgn;
                    turn_deg = ($urandom_range(7) == 0) ? $urandom_range(200, 160)
                                                        : $urandom_range(45, 3);
                    ang = ang + sgn * turn_deg * DEG;
                end
                send_sample(1'b0, 8'($urandom_range(255)), 8'($urandom_range(191)),
                            1'($urandom_range(1)));
                done += count + 1;
            end else if (kind < 8) begin
                // Tap near the center or one of the four buttons.
                k = $urandom_range(4);
                if (k == 0) begin
                    bx = 0;
                    by = 0;
                end else begin
                    bx = $signed(btn_pos[k-1][7:0]);
                    by = $signed(btn_pos[k-1][15:8]);
                end
                count = $urandom_range(3, 1);
                repeat (count) begin
                    jx = $urandom_range(50);
                    jy = $urandom_range(50);
                    jx -= 25;
                    jy -= 25;
                    send_sample(1'b1, screen_coord(ctr_x, bx + jx, 255),
                                screen_coord(ctr_y, by + jy, 191), $urandom_range(3) == 0);
                end
                send_sample(1'b0, 8'($urandom_range(255)), 8'($urandom_range(191)),
                            1'($urandom_range(1)));
                done += count + 1;
            end else begin
                // Noise: samples with every field random.
                count = $urandom_range(4, 1);
                repeat (count)
                    send_sample(1'($urandom_range(1)), 8'($urandom_range(255)),
                                8'($urandom_range(191)), 1'($urandom_range(1)));
                done += count;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-placed gestures on the reset geometry.
    task automatic test_directed();
        gap_pct   = 0;
        stall_pct = 0;
        send_sample(1'b0, 8'd0,   8'd0,   1'b1);   // take with nothing pending
        send_sample(1'b1, 8'd128, 8'd96,  1'b0);   // center tap
        send_sample(1'b0, 8'd128, 8'd96,  1'b1);
        send_sample(1'b1, 8'd128, 8'd41,  1'b0);   // menu tap
        send_sample(1'b0, 8'd128, 8'd41,  1'b1);
        send_sample(1'b1, 8'd183, 8'd96,  1'b0);   // forward tap
        send_sample(1'b0, 8'd183, 8'd96,  1'b1);
        send_sample(1'b1, 8'd73,  8'd96,  1'b0);   // rewind tap
        send_sample(1'b0, 8'd73,  8'd96,  1'b1);
        send_sample(1'b1, 8'd128, 8'd151, 1'b0);   // play tap
        send_sample(1'b0, 8'd128, 8'd151, 1'b1);
        send_sample(1'b1, 8'd200, 8'd20,  1'b0);   // tap that hits no button
        send_sample(1'b0, 8'd200, 8'd20,  1'b1);
        send_sample(1'b1, 8'd178, 8'd96,  1'b0);   // press enters the ring
        send_sample(1'b1, 8'd171, 8'd121, 1'b1);   // 30 degrees one way, report mid-press
        send_sample(1'b1, 8'd178, 8'd96,  1'b1);   // back the other way
        send_sample(1'b1, 8'd79,  8'd105, 1'b1);   // near half-turn jump
        send_sample(1'b1, 8'd128, 8'd96,  1'b0);   // leave the ring through the center
        send_sample(1'b0, 8'd128, 8'd96,  1'b1);   // release after a step: no tap
        send_sample(1'b1, 8'd255, 8'd191, 1'b1);   // panel corners
        send_sample(1'b1, 8'd0,   8'd0,   1'b0);
        send_sample(1'b0, 8'd0,   8'd0,   1'b1);
    endtask

    // Random traffic under each idling mode, on the reset geometry and then random ones.
    task automatic test_random_traffic();
        int mode;
        for (mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 49; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 49; end
                default: begin gap_pct = 22; stall_pct = 22; end
            endcase
            if (mode != 0) begin
                logic [7:0] ro;
                ro = 8'($urandom_range(120, 40));
                program_geometry(8'($urandom_range(195, 60)), 8'($urandom_range(140, 50)), ro,
                                 8'($urandom_range(ro - 10, 5)),
                                 {rand_offset(), rand_offset()}, {rand_offset(), rand_offset()},
                                 {rand_offset(), rand_offset()}, {rand_offset(), rand_offset()});
            end
            run_gestures(170);
        end
    endtask

    // Extreme geometries: corner centers, zero and full radii, an inverted ring,
    // button offsets at the signed byte limits.
    task automatic test_geometry_sweep();
        gap_pct   = 22;
        stall_pct = 22;
        program_geometry(8'd0, 8'd0, 8'd255, 8'd0,
                         16'h0000, 16'hFFFF, 16'h8080, 16'h7F7F);
        run_gestures(80);
        program_geometry(8'd255, 8'd191, 8'd0, 8'd0,
                         16'h807F, 16'h7F80, 16'h0000, 16'hFFFF);
        run_gestures(80);
        program_geometry(8'd128, 8'd96, 8'd0, 8'd255,
                         16'hFFFF, 16'h0000, 16'h7F7F, 16'h8080);
        run_gestures(80);
        program_geometry(8'd128, 8'd96, 8'd255, 8'd255,
                         16'h00EC, 16'h1400, 16'hEC00, 16'h0014);
        run_gestures(80);
    endtask

    // Long output hold-off while samples keep coming, so the input backs up.
    task automatic test_output_stall();
        program_geometry(twgd_pkg::RST_CENTER_X, twgd_pkg::RST_CENTER_Y,
                         twgd_pkg::RST_OUTER_RADIUS, twgd_pkg::RST_INNER_RADIUS,
                         twgd_pkg::RST_MENU_POS, twgd_pkg::RST_FORWARD_POS,
                         twgd_pkg::RST_REWIND_POS, twgd_pkg::RST_PLAY_POS);
        gap_pct   = 0;
        stall_pct = 0;
        hold_armed++;
        run_gestures(60);
    endtask

    initial begin
        // Drive every input before the first edge and load the reset shadows.
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        ctr_x      = twgd_pkg::RST_CENTER_X;
        ctr_y      = twgd_pkg::RST_CENTER_Y;
        r_out      = twgd_pkg::RST_OUTER_RADIUS;
        r_in       = twgd_pkg::RST_INNER_RADIUS;
        btn_pos[0] = twgd_pkg::RST_MENU_POS;
        btn_pos[1] = twgd_pkg::RST_FORWARD_POS;
        btn_pos[2] = twgd_pkg::RST_REWIND_POS;
        btn_pos[3] = twgd_pkg::RST_PLAY_POS;
        anc_x      = '0;
        anc_y      = '0;
        last_x     = '0;
        last_y     = '0;
        ringed     = 1'b0;
        stepped    = 1'b0;
        pressed    = 1'b0;
        sticky     = '0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_traffic();
        test_geometry_sweep();
        test_output_stall();
        wait_drain();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/twgd_pkg.sv
design/twgd_cordic_lane.sv
design/twgd_datapath.sv
design/twgd_ctrl.sv
design/touch_wheel_gesture_decoder_unit.sv
dv/testbench.sv
